[sv/idq_pkg.sv]
package idq_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_POP_BACK   = 3'd1,
        REQ_PUSH_FRONT = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_READ       = 3'd4,
        REQ_DELETE     = 3'd5
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Broadcast to every cell in the chain for one accepted request.
    typedef struct packed {
        logic push_back;
        logic push_front;
        logic shift_down;
    } cell_ctl_t;

endpackage

[sv/idq_req_if.sv]
interface idq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] value_in;
    logic [4:0]         position;

    modport source (output valid, req_type, value_in, position, input ready);
    modport sink   (input valid, req_type, value_in, position, output ready);
endinterface

[sv/idq_rsp_if.sv]
interface idq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [5:0]         count;

    modport source (output valid, value_out, status, count, input ready);
    modport sink   (input valid, value_out, status, count, output ready);
endinterface

[sv/idq_cell.sv]
module idq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 5,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  idq_pkg::cell_ctl_t    ctl,
    input  logic [IW-1:0]         sel,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] rd
);
    import idq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.push_front)
        begin
            data_next = left_data;
        end
        else if (ctl.push_back && (sel == IW'(INDEX)))
        begin
            data_next = word;
        end
        else if (ctl.shift_down && (IW'(INDEX) >= sel))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // Only the selected cell drives the read bus; the others contribute zero.
    assign rd   = (sel == IW'(INDEX)) ? data_reg : '0;

endmodule

[sv/indexed_deque.sv]
// Indexed double-ended queue of signed words held in a row of register cells.
// Requests arrive on the req channel (valid/ready) and carry a request type,
// a value for pushes and a position for read and delete. Each request yields
// exactly one response on the rsp channel: the value taken or read, a status
// (ok, empty, bad position, full) and the element count after the request.
// A request's response is registered and is valid in the cycle after it is
// accepted; one request per cycle is sustained while the receiver takes each
// response, since every cell shifts or loads in parallel and a read is a
// one-hot select across the row into the output register.
// The response register decouples the two sides: req.ready is high whenever
// the response register is empty or being drained, so a stalled receiver
// holds the pending response and blocks only the request behind it.
// Reset clears the element count and the response valid flag; cell contents
// are left as they are and are never read before they are written.
module indexed_deque #(
    parameter int DEPTH      = idq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = idq_pkg::DATA_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    idq_req_if.sink   req,
    idq_rsp_if.source rsp
);
    import idq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  out_valid_reg;
    logic signed [31:0]    value_reg;
    logic signed [31:0]    value_next;
    status_t               status_reg;
    status_t               status_next;
    logic [5:0]            count_out_reg;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  bad_pos;
    logic                  take_value;
    cell_ctl_t             ctl;
    logic [IW-1:0]         sel;
    logic [DATA_WIDTH-1:0] word;
    logic signed [DATA_WIDTH-1:0] rd_word;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign word    = DATA_WIDTH'(req.value_in);
    assign full    = (32'(count_reg) >= 32'(DEPTH));
    assign empty   = (count_reg == '0);
    assign bad_pos = (32'(req.position) >= 32'(count_reg));

    always_comb
    begin
        ctl         = '0;
        sel         = '0;
        take_value  = 1'b0;
        status_next = ST_OK;
        count_next  = count_reg;
        case (req.req_type)
            REQ_PUSH_BACK:
            begin
                sel = IW'(count_reg);
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.push_back = accept;
                    count_next    = count_reg + 1'b1;
                end
            end
            REQ_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.push_front = accept;
                    count_next     = count_reg + 1'b1;
                end
            end
            REQ_POP_BACK:
            begin
                sel = IW'(count_reg - 1'b1);
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    take_value = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    take_value     = 1'b1;
                    ctl.shift_down = accept;
                    count_next     = count_reg - 1'b1;
                end
            end
            REQ_READ:
            begin
                sel = IW'(req.position);
                if (bad_pos)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    take_value = 1'b1;
                end
            end
            REQ_DELETE:
            begin
                sel = IW'(req.position);
                if (bad_pos)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    ctl.shift_down = accept;
                    count_next     = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_data;
            logic [DATA_WIDTH-1:0] right_data;

            if (g == 0)
            begin : g_first
                assign left_data = word;
            end
            else
            begin : g_mid_left
                assign left_data = cell_data[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_data = cell_data[g];
            end
            else
            begin : g_mid_right
                assign right_data = cell_data[g+1];
            end

            idq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IW         (IW),
                .INDEX      (g)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .sel        (sel),
                .word       (word),
                .left_data  (left_data),
                .right_data (right_data),
                .data       (cell_data[g]),
                .rd         (cell_rd[g])
            );
        end
    endgenerate

    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word = rd_word | cell_rd[i];
        end
    end

    assign value_next = take_value ? 32'(rd_word) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg     <= value_next;
            status_reg    <= status_next;
            count_out_reg <= 6'(count_next);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.value_out = value_reg;
    assign rsp.status    = status_reg;
    assign rsp.count     = count_out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
        else $error("element count above depth");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (req.req_type == REQ_PUSH_BACK || req.req_type == REQ_PUSH_FRONT))
        |=> (rsp.status == ST_FULL) && (count_reg == $past(count_reg)))
        else $error("push into full store not refused");

    a_delete_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_DELETE) |=> (rsp.value_out == '0))
        else $error("delete returned a nonzero value");

    a_count_echo: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rsp.count == 6'(count_reg)))
        else $error("response count does not match stored count");
`endif

endmodule

[test/indexed_deque_tb.sv]
`timescale 1ns / 100ps

module indexed_deque_tb;

    import idq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int TAIL_ITEMS     = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Request codes outside the enum; the block ignores them.
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] word;
        logic [4:0]         pos;
    } dq_request_t;

    typedef struct packed {
        logic signed [31:0] word;
        status_t            status;
        logic [5:0]         count;
    } dq_response_t;

    logic clk;
    logic rst_n;

    idq_req_if req_ch ();
    idq_rsp_if rsp_ch ();

    indexed_deque DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dq_request_t        pending_requests[$];
    dq_response_t       expected_responses[$];
    logic signed [31:0] shadow_words[$];
    dq_request_t        current_request;
    int                 gen_fill;
    int                 send_gap;
    int                 recv_stall;
    int                 stall_cycles;
    int                 errors;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Expected response for one accepted request; updates the shadow copy.
    function automatic dq_response_t apply_request(dq_request_t r);
        dq_response_t rsp;
        rsp.word   = '0;
        rsp.status = ST_OK;
        case (r.kind)
            REQ_PUSH_BACK:
                if (shadow_words.size() >= DEPTH) rsp.status = ST_FULL;
                else shadow_words.push_back(r.word);
            REQ_PUSH_FRONT:
                if (shadow_words.size() >= DEPTH) rsp.status = ST_FULL;
                else shadow_words.push_front(r.word);
            REQ_POP_BACK:
                if (shadow_words.size() == 0) rsp.status = ST_EMPTY;
                else rsp.word = shadow_words.pop_back();
            REQ_POP_FRONT:
                if (shadow_words.size() == 0) rsp.status = ST_EMPTY;
                else rsp.word = shadow_words.pop_front();
            REQ_READ:
                if (r.pos >= shadow_words.size()) rsp.status = ST_BADPOS;
                else rsp.word = shadow_words[r.pos];
            REQ_DELETE:
                // A delete reports zero even though it removes a word.
                if (r.pos >= shadow_words.size()) rsp.status = ST_BADPOS;
                else shadow_words.delete(r.pos);
            default: ;
        endcase
        rsp.count = 6'(shadow_words.size());
        return rsp;
    endfunction

    // Queues a request and tracks the fill level so the generator can aim
    // positions at stored words.
    task automatic queue_request(logic [2:0] kind, logic signed [31:0] word, logic [4:0] pos);
        dq_request_t r;
        r.kind = kind;
        r.word = word;
        r.pos  = pos;
        pending_requests.push_back(r);
        case (kind)
            REQ_PUSH_BACK, REQ_PUSH_FRONT:
                if (gen_fill < DEPTH) gen_fill++;
            REQ_POP_BACK, REQ_POP_FRONT:
                if (gen_fill > 0) gen_fill--;
            REQ_DELETE:
                if (pos < gen_fill) gen_fill--;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 15))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] random_pos();
        if (gen_fill > 0 && $urandom_range(0, 3) != 0)
            return 5'($urandom_range(0, gen_fill - 1));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [2:0] random_kind(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
        case (mode)
            MODE_FILL:
                if (roll < 80)
                    return ($urandom_range(0, 1) != 0) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            MODE_DRAIN:
                if (roll < 80)
                    case ($urandom_range(0, 2))
                        0: return REQ_POP_BACK;
                        1: return REQ_POP_FRONT;
                        default: return REQ_DELETE;
                    endcase
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: return REQ_PUSH_BACK;
            1: return REQ_POP_BACK;
            2: return REQ_PUSH_FRONT;
            3: return REQ_POP_FRONT;
            4: return REQ_READ;
            default: return REQ_DELETE;
        endcase
    endfunction

    initial
    begin
        int made;
        int mode;
        int run;
        logic [2:0] kind;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.value_in = '0;
        req_ch.position = '0;
        rsp_ch.ready    = 1'b0;
        gen_fill        = 0;
        errors          = 0;

        // Empty store: taking and indexed requests must fail; then spare codes, pushes, reads, deletes and pops.
        queue_request(REQ_POP_BACK,   '0, '0);
        queue_request(REQ_POP_FRONT,  '0, '0);
        queue_request(REQ_READ,       '0, 5'd0);
        queue_request(REQ_DELETE,     '0, 5'd31);
        queue_request(REQ_SPARE_LO,   32'sh1234_5678, 5'd3);
        queue_request(REQ_SPARE_HI,   -32'sd1, 5'd31);
        queue_request(REQ_PUSH_BACK,  32'sh7FFF_FFFF, 5'd31);
        queue_request(REQ_PUSH_FRONT, 32'sh8000_0000, '0);
        queue_request(REQ_PUSH_BACK,  '0, '0);
        queue_request(REQ_PUSH_BACK,  -32'sd1, '0);
        queue_request(REQ_READ,       '0, 5'd0);
        queue_request(REQ_READ,       '0, 5'd1);
        queue_request(REQ_READ,       '0, 5'd3);
        queue_request(REQ_READ,       '0, 5'd4);
        queue_request(REQ_READ,       '0, 5'd31);
        queue_request(REQ_DELETE,     '0, 5'd1);
        queue_request(REQ_READ,       '0, 5'd1);
        queue_request(REQ_DELETE,     '0, 5'd3);
        queue_request(REQ_POP_FRONT,  '0, '0);
        queue_request(REQ_POP_BACK,   '0, '0);
        queue_request(REQ_POP_BACK,   '0, '0);
        queue_request(REQ_POP_FRONT,  '0, '0);

        // Random phases biased towards pushes (fill), towards pops and deletes (drain), or mixed.
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            mode = $urandom_range(MODE_FILL, MODE_MIX);
            run  = $urandom_range(20, 60);
            repeat (run)
            begin
                kind = random_kind(mode);
                queue_request(kind, random_word(), random_pos());
                if (kind != REQ_SPARE_LO && kind != REQ_SPARE_HI)
                    made++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        logic send;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap     = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_responses.push_back(apply_request(current_request));
            if (!req_ch.valid || req_ch.ready)
            begin
                send = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(0, 9);
                else if (pending_requests.size() > 0)
                begin
                    current_request = pending_requests.pop_front();
                    send = 1'b1;
                end
                req_ch.valid <= send;
                if (send)
                begin
                    req_ch.req_type <= current_request.kind;
                    req_ch.value_in <= current_request.word;
                    req_ch.position <= current_request.pos;
                end
            end
        end
    end

    // Response monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        dq_response_t want;
        logic take;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_stall   = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected response: value %0d status %0d count %0d",
                                 $realtime, rsp_ch.value_out, rsp_ch.status, rsp_ch.count);
                    errors++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (rsp_ch.value_out !== want.word || rsp_ch.status !== want.status
                        || rsp_ch.count !== want.count)
                    begin
                        // Fields are printed as value/status/count.
                        if (errors < 10)
                            $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     $realtime, want.word, want.status, want.count,
                                     rsp_ch.value_out, rsp_ch.status, rsp_ch.count);
                        errors++;
                    end
                end
            end
            take = 1'b1;
            if (recv_stall > 0)
            begin
                recv_stall--;
                take = 1'b0;
            end
            else if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0)
            begin
                recv_stall = $urandom_range(0, 9);
                take = 1'b0;
            end
            rsp_ch.ready <= take;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        stall_cycles = 0;
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("indexed_deque_tb: done, errors");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        while (pending_requests.size() != 0 || req_ch.valid || expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("indexed_deque_tb: done, clean");
        else
            $display("indexed_deque_tb: done, errors");
        $finish;
    end

endmodule
